// File: hdl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg: shared types and constants for the MT19937 generator
// Word count, twist and temper constants, command codes, sequencer states.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int WORDS     = 624;
    localparam int SHIFT     = 397;
    localparam int IDX_W     = $clog2(WORDS + 1);
    localparam int WORD_W    = 32;
    localparam int RESULT_W  = 53;
    localparam int HIGH_W    = WORD_W - 5;
    localparam int LOW_W     = WORD_W - 6;

    localparam logic [WORD_W-1:0] INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] MATRIX   = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WORDS - 1);
    localparam logic [IDX_W-1:0] FULL_IDX  = IDX_W'(WORDS);
    localparam logic [IDX_W-1:0] WRAP_IDX  = IDX_W'(WORDS - SHIFT);
    localparam logic [IDX_W-1:0] SHIFT_IDX = IDX_W'(SHIFT);

    typedef enum logic [1:0] {
        CMD_SEED   = 2'd0,
        CMD_DRAW32 = 2'd1,
        CMD_DRAW53 = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_SD_MUL,
        S_SD_ADD,
        S_DRAW_CHK,
        S_DRAW_USE,
        S_TW_LOAD,
        S_TW_A,
        S_TW_B,
        S_TW_C,
        S_DONE
    } state_t;

endpackage

// File: hdl/mtg_ram.sv
// ----------------------------------------------------------------------------
// mtg_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/mersenne_twister_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator: MT19937 32-bit generator
// Seed, 32-bit draw and 53-bit mantissa draw over a 624-word state RAM.
// ----------------------------------------------------------------------------
// One transaction at a time; in_stall is high from acceptance until the
// result is loaded into the output register. Seeding writes the state word by
// word through the single multiplier, each word passing S_SD_MUL and then
// S_SD_ADD. A 32-bit draw reads one word and a 53-bit draw two, unless the
// read index has reached 624: the draw then first twists the whole state,
// word by word through the one RAM read port. Until the first seed the state is all zeros and
// draws return zero without touching the RAM, so no clearing pass is needed
// after reset.
module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [WORD_W-1:0]   seed_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [RESULT_W-1:0] random_value
);

    localparam int ADDR_W = $clog2(WORDS);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic                second_reg, second_next;
    logic                seeded_reg, seeded_next;
    logic [IDX_W-1:0]    read_index_reg, read_index_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;

    logic [HIGH_W-1:0]   a_reg, a_next;
    logic [WORD_W-1:0]   p_reg, p_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic [WORD_W-1:0]   nxt_reg, nxt_next;
    logic                cur_msb_reg, cur_msb_next;
    logic [RESULT_W-1:0] result_reg, result_next;
    logic [RESULT_W-1:0] random_value_reg, random_value_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;

    logic [WORD_W-1:0]   mix;
    logic [WORD_W-1:0]   seed_word;
    logic [WORD_W-1:0]   twist_y;
    logic [WORD_W-1:0]   twist_word;
    logic [WORD_W-1:0]   drawn;
    logic [IDX_W-1:0]    nxt_idx;
    logic [IDX_W-1:0]    far_idx;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mix        = p_reg ^ (p_reg >> 30);
    assign seed_word  = prod_reg + {{(WORD_W-IDX_W){1'b0}}, idx_reg};
    assign twist_y    = {cur_msb_reg, nxt_reg[WORD_W-2:0]};
    assign twist_word = rd_data ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX : '0);
    assign nxt_idx    = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign far_idx    = (idx_reg < WRAP_IDX) ? idx_reg + SHIFT_IDX : idx_reg - WRAP_IDX;
    assign drawn      = (state_reg == S_DRAW_USE) ? temper(rd_data) : '0;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign random_value = random_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_NONE;
            second_reg     <= 1'b0;
            seeded_reg     <= 1'b0;
            read_index_reg <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            second_reg     <= second_next;
            seeded_reg     <= seeded_next;
            read_index_reg <= read_index_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg            <= a_next;
        p_reg            <= p_next;
        prod_reg         <= prod_next;
        nxt_reg          <= nxt_next;
        cur_msb_reg      <= cur_msb_next;
        result_reg       <= result_next;
        random_value_reg <= random_value_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        second_next       = second_reg;
        seeded_next       = seeded_reg;
        read_index_next   = read_index_reg;
        idx_next          = idx_reg;
        out_valid_next    = out_valid_reg && out_stall;
        a_next            = a_reg;
        p_next            = p_reg;
        prod_next         = prod_reg;
        nxt_next          = nxt_reg;
        cur_msb_next      = cur_msb_reg;
        result_next       = result_reg;
        random_value_next = random_value_reg;
        wr_en             = 1'b0;
        wr_addr           = idx_reg[ADDR_W-1:0];
        wr_data           = seed_word;
        rd_en             = 1'b0;
        rd_addr           = read_index_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd_t'(cmd);
                    second_next = 1'b0;
                    p_next      = seed_value;
                    result_next = '0;
                    unique case (cmd_t'(cmd))
                        CMD_SEED:               state_next = S_SEED;
                        CMD_DRAW32, CMD_DRAW53: state_next = S_DRAW_CHK;
                        default:                state_next = S_DONE;
                    endcase
                end
            end

            S_SEED:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = p_reg;
                idx_next   = IDX_W'(1);
                state_next = S_SD_MUL;
            end

            S_SD_MUL:
            begin
                prod_next  = INIT_MUL * mix;
                state_next = S_SD_ADD;
            end

            S_SD_ADD:
            begin
                wr_en  = 1'b1;
                p_next = seed_word;
                if (idx_reg == LAST_IDX)
                begin
                    seeded_next     = 1'b1;
                    read_index_next = FULL_IDX;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SD_MUL;
                end
            end

            S_DRAW_CHK, S_DRAW_USE:
            begin
                if ((state_reg == S_DRAW_CHK) && seeded_reg)
                begin
                    if (read_index_reg == FULL_IDX)
                    begin
                        idx_next   = '0;
                        state_next = S_TW_LOAD;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_DRAW_USE;
                    end
                end
                else
                begin
                    // unseeded draws (still in S_DRAW_CHK) take a zero word; S_DRAW_USE takes the tempered RAM word
                    if (state_reg == S_DRAW_USE)
                    begin
                        read_index_next = read_index_reg + 1'b1;
                    end
                    if ((cmd_reg == CMD_DRAW53) && !second_reg)
                    begin
                        a_next      = drawn[WORD_W-1:5];
                        second_next = 1'b1;
                        state_next  = S_DRAW_CHK;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_DRAW53)
                        begin
                            result_next = {a_reg, drawn[WORD_W-1:6]};
                        end
                        else
                        begin
                            result_next = {{(RESULT_W-WORD_W){1'b0}}, drawn};
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_TW_LOAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_TW_A;
            end

            S_TW_A:
            begin
                if (idx_reg == '0)
                begin
                    cur_msb_next = rd_data[WORD_W-1];
                end
                rd_en      = 1'b1;
                rd_addr    = nxt_idx[ADDR_W-1:0];
                state_next = S_TW_B;
            end

            S_TW_B:
            begin
                nxt_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = far_idx[ADDR_W-1:0];
                state_next = S_TW_C;
            end

            S_TW_C:
            begin
                wr_en        = 1'b1;
                wr_data      = twist_word;
                cur_msb_next = nxt_reg[WORD_W-1];
                if (idx_reg == LAST_IDX)
                begin
                    read_index_next = '0;
                    state_next      = S_DRAW_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TW_A;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    random_value_next = result_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        read_index_reg <= FULL_IDX)
        else $error("read index beyond word count");

    a_seed_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SD_ADD) && (idx_reg == LAST_IDX)
        |=> seeded_reg && (read_index_reg == FULL_IDX))
        else $error("seeding did not leave index at word count");

    a_twist_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_TW_A) || (state_reg == S_TW_B) || (state_reg == S_TW_C))
        |-> (idx_reg <= LAST_IDX) && seeded_reg)
        else $error("twist index out of range or twist while unseeded");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> (state_reg != S_IDLE))
        else $error("accepted transaction not started");

    a_twist_before_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW_USE) |-> $past(read_index_reg) != FULL_IDX)
        else $error("draw read past end of state");
`endif

endmodule

// File: verif/mersenne_twister_generator_test.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_test: testbench for the MT19937 generator
// A directed table (unseeded zero state, unused command, seeds at the
// extremes, draws that run across a twist) is followed by three random phases
// with shifting idle on both sides. Every result is checked in order, against
// a fixed table value or an independent software twister kept in step with each accepted transaction.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_test
    import mtg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_CYCLES     = 64;
    localparam int PHASE_ITEMS      = 70;
    localparam int LAST_PHASE_ITEMS = 460;

    typedef struct packed {
        cmd_t                op;
        logic [WORD_W-1:0]   seed;
        int                  count;
        logic                fixed;
        logic [RESULT_W-1:0] value;
    } stim_row_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [1:0]          cmd        = CMD_NONE;
    logic [WORD_W-1:0]   seed_value = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [RESULT_W-1:0] random_value;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int fail_count    = 0;

    bit [WORD_W-1:0]   mt_state [WORDS];
    int                mt_pos = 0;
    bit [RESULT_W-1:0] pending_values [$];
    bit [RESULT_W-1:0] expected_value;

    stim_row_t directed_rows [20] = '{
        '{CMD_DRAW32, 32'h0000_0000,   1, 1'b1, '0},
        '{CMD_DRAW53, 32'hFFFF_FFFF,   1, 1'b1, '0},
        '{CMD_NONE,   32'h1234_5678,   1, 1'b1, '0},
        // unseeded: in the software model the last of these straddles the twist of the zero state
        '{CMD_DRAW53, 32'h0000_0000, 311, 1'b1, '0},
        '{CMD_DRAW32, 32'hFFFF_FFFF,   2, 1'b1, '0},
        '{CMD_SEED,   32'h0000_0000,   1, 1'b1, '0},
        '{CMD_DRAW32, 32'hFFFF_FFFF,   3, 1'b0, '0},
        '{CMD_DRAW53, 32'h0000_0000,   2, 1'b0, '0},
        '{CMD_SEED,   32'hFFFF_FFFF,   1, 1'b1, '0},
        '{CMD_DRAW53, 32'hFFFF_FFFF,   2, 1'b0, '0},
        '{CMD_NONE,   32'hFFFF_FFFF,   1, 1'b1, '0},
        '{CMD_DRAW32, 32'h0000_0000,   1, 1'b0, '0},
        '{CMD_SEED,   32'd5489,        1, 1'b1, '0},
        '{CMD_DRAW32, 32'h0000_0000,   2, 1'b0, '0},
        '{CMD_SEED,   32'h8000_0000,   1, 1'b1, '0},
        '{CMD_DRAW32, 32'h5555_5555,   1, 1'b0, '0},
        // last of these takes word 623 and the first word after a twist
        '{CMD_DRAW53, 32'hAAAA_AAAA, 312, 1'b0, '0},
        '{CMD_DRAW32, 32'h0000_0000,   2, 1'b0, '0},
        '{CMD_SEED,   32'h0000_0001,   1, 1'b1, '0},
        '{CMD_DRAW53, 32'h0000_0000,   1, 1'b0, '0}
    };

    mersenne_twister_generator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    always #10 clk = ~clk;

    function automatic void twist_state();
        bit [WORD_W-1:0] y;
        bit [WORD_W-1:0] v;
        for (int i = 0; i < WORDS; i++)
        begin
            y = {mt_state[i][WORD_W-1], mt_state[(i + 1) % WORDS][WORD_W-2:0]};
            v = mt_state[(i + SHIFT) % WORDS] ^ (y >> 1);
            if (y[0])
                v ^= MATRIX;
            mt_state[i] = v;
        end
        mt_pos = 0;
    endfunction

    function automatic bit [WORD_W-1:0] next_tempered();
        bit [WORD_W-1:0] y;
        if (mt_pos >= WORDS)
            twist_state();
        y = mt_state[mt_pos];
        mt_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_B;
        y ^= (y << 15) & TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    function automatic void load_seed(bit [WORD_W-1:0] s);
        bit [WORD_W-1:0] p;
        mt_state[0] = s;
        for (int i = 1; i < WORDS; i++)
        begin
            p = mt_state[i - 1];
            mt_state[i] = INIT_MUL * (p ^ (p >> 30)) + WORD_W'(i);
        end
        mt_pos = WORDS;
    endfunction

    function automatic bit [RESULT_W-1:0] predict_value(cmd_t op, bit [WORD_W-1:0] s);
        bit [WORD_W-1:0] hi;
        bit [WORD_W-1:0] lo;
        case (op)
            CMD_SEED:
            begin
                load_seed(s);
                return '0;
            end
            CMD_DRAW32:
                return RESULT_W'(next_tempered());
            CMD_DRAW53:
            begin
                hi = next_tempered();
                lo = next_tempered();
                return {hi[WORD_W-1:5], lo[WORD_W-1:6]};
            end
            default:
                return '0;
        endcase
    endfunction

    task automatic send_item(cmd_t op, bit [WORD_W-1:0] s, bit fixed,
                             bit [RESULT_W-1:0] value);
        bit [RESULT_W-1:0] predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        seed_value <= s;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_value(op, s);
        pending_values.push_back(fixed ? value : predicted);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_values.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transaction: random_value=%0h", random_value);
            end
            else
            begin
                expected_value = pending_values.pop_front();
                if (random_value !== expected_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("random_value mismatch: expected %0h got %0h",
                                 expected_value, random_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[mersenne_twister_generator] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        cmd_t            op;
        bit [WORD_W-1:0] s;
        int unsigned     pick;
        int              seed_odds;

        send_idle_pct = 37;
        recv_idle_pct = 71;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].count; k++)
                send_item(directed_rows[r].op, directed_rows[r].seed,
                          directed_rows[r].fixed, directed_rows[r].value);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 37 : 0;
            // no reseeding in the last phase so the read index wraps
            seed_odds     = (phase == 0) ? 16 : (phase == 1) ? 40 : 0;
            for (int n = 0; n < ((phase == 2) ? LAST_PHASE_ITEMS : PHASE_ITEMS); n++)
            begin
                pick = $urandom_range(99);
                if (seed_odds != 0 && $urandom_range(seed_odds - 1) == 0)
                    op = CMD_SEED;
                else if (pick < 3)
                    op = CMD_NONE;
                else if (pick < 43)
                    op = CMD_DRAW32;
                else
                    op = CMD_DRAW53;
                case ($urandom_range(15))
                    0:       s = '0;
                    1:       s = '1;
                    default: s = $urandom();
                endcase
                send_item(op, s, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_values.size() == 0)
            $display("[mersenne_twister_generator] OK");
        else
            $display("[mersenne_twister_generator] ERROR");
        $finish;
    end

endmodule
